>>> hw/rtl/mfi_pkg.sv
// ----------------------------------------------------------------------------
// mfi_pkg: shared types and constants for the money flow index block
// Beat layouts, divider control/status and fixed field widths.
// ----------------------------------------------------------------------------
package mfi_pkg;

  localparam int PRICE_W   = 24;   // width of a price field
  localparam int VOLUME_W  = 32;   // width of the volume field
  localparam int INDEX_W   = 23;   // width of the index result
  localparam int CFG_W     = 7;    // width of the window length register
  localparam int SUM_W     = 64;   // running sums wrap at this width
  localparam int NUM_W     = 2 * SUM_W;
  localparam int CNT_W     = $clog2(NUM_W);

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd14;

  // 6553600 = 25 << 18
  localparam int SCALE_SHIFT = 18;

  typedef struct packed {
    logic                series_start;
    logic [PRICE_W-1:0]  bar_high;
    logic [PRICE_W-1:0]  bar_low;
    logic [PRICE_W-1:0]  bar_close;
    logic [VOLUME_W-1:0] bar_volume;
  } in_beat_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_value;
    logic               window_empty;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic full;    // run all quotient bits, not only the low ones
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> hw/rtl/mfi_ram.sv
// ----------------------------------------------------------------------------
// mfi_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mfi_div.sv
// ----------------------------------------------------------------------------
// mfi_div: radix-2 restoring divider, one quotient bit per cycle
// Returns the low INDEX_W bits of num / den. In short mode the top quotient
// bits are known to be zero, so only the last INDEX_W steps are run.
// ----------------------------------------------------------------------------
module mfi_div
  import mfi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  div_ctl_t           ctl,
  input  logic [NUM_W-1:0]   num,
  input  logic [SUM_W-1:0]   den,
  output div_sts_t           sts,
  output logic [INDEX_W-1:0] quo
);

  logic [SUM_W:0]     rem;
  logic [NUM_W-1:0]   shf;
  logic [SUM_W-1:0]   dsr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic [SUM_W:0]     trial;
  logic [SUM_W:0]     diff;
  logic               fits;

  assign trial = {rem[SUM_W-1:0], shf[NUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        if (ctl.full) begin
          cnt <= CNT_W'(NUM_W - 1);
        end else begin
          cnt <= CNT_W'(INDEX_W - 1);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dsr <= den;
      quo <= '0;
      if (ctl.full) begin
        rem <= '0;
        shf <= num;
      end else begin
        // high part of num is below den: it is the partial remainder already
        rem <= {1'b0, num[SUM_W+INDEX_W-1:INDEX_W]};
        shf <= {num[INDEX_W-1:0], {(NUM_W-INDEX_W){1'b0}}};
      end
    end else if (busy) begin
      shf <= {shf[NUM_W-2:0], 1'b0};
      if (fits) begin
        rem <= diff;
        quo <= {quo[INDEX_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[INDEX_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> hw/rtl/money_flow_index.sv
// ----------------------------------------------------------------------------
// money_flow_index: money flow index over a sliding window of price bars
// Bar in, optional index out; flow history kept in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one price bar per beat. out_valid/
//   out_ready/out_data carry one index beat, produced for every bar once the
//   window has been filled (bar P+1 of a series onward).
//   cfg_we/cfg_wdata write the window length; a write restarts the series.
// Timing: one bar at a time. The first bar of a series only records its
//   typical price; a bar that only fills the window also does the ring
//   read-modify-write and sums. A bar with a result then goes through the
//   scale step, the divider and the hand-over to the output register. The
//   radix-2 divider sets the pace of such bars. If the sums have wrapped (only
//   possible with widened parameters) the divider runs 128 steps instead of 23.
// Reset: window length returns to 14, sums and counters clear. The ring RAM
//   is not cleared; entries are read only after being written.
// Stall: the output register holds its beat until taken; the next bar is
//   accepted and processed meanwhile, and only its hand-over waits.
// ----------------------------------------------------------------------------
module money_flow_index
  import mfi_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int PRICE_BITS  = 24,
  parameter int VOLUME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int PB   = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int TYPW = PB + 2;
  localparam int FW   = TYPW + VOLUME_BITS;
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int PW   = $clog2(MAX_WINDOW + 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUB   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_TOT   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]             state;
  logic [CFG_W-1:0]       window_length;
  logic [SUM_W-1:0]       pos_sum;
  logic [SUM_W-1:0]       neg_sum;
  logic [TYPW-1:0]        prev_typ;
  logic [AW-1:0]          ring_pos;
  logic [PW-1:0]          bars_seen;

  logic [TYPW-1:0]        typ;
  logic [VOLUME_BITS-1:0] vol;
  logic [FW-1:0]          flow;
  logic                   neg;
  logic [AW-1:0]          slot;
  logic [SUM_W-1:0]       total;
  logic [SUM_W+3:0]       pos9;
  out_beat_t              res;

  logic [PW-1:0]          p;
  logic [31:0]            wl_ext;
  logic [AW-1:0]          slot_c;
  logic [PW-1:0]          slot_inc;
  logic [AW-1:0]          ring_pos_next;
  logic [PW-1:0]          bars_seen_next;
  logic                   accept;

  logic                   ram_we;
  logic [FW:0]            ram_rdata;

  div_ctl_t               div_ctl;
  div_sts_t               div_sts;
  logic [NUM_W-1:0]       div_num;
  logic [INDEX_W-1:0]     div_quo;

  // window size clamped to [1, MAX_WINDOW]
  assign wl_ext = 32'(window_length);
  always_comb begin
    if (wl_ext == 32'd0) begin
      p = PW'(1);
    end else if (wl_ext > 32'(MAX_WINDOW)) begin
      p = PW'(MAX_WINDOW);
    end else begin
      p = PW'(wl_ext);
    end
  end

  assign slot_c         = (PW'(ring_pos) >= p) ? '0 : ring_pos;
  assign slot_inc       = PW'(slot) + 1'b1;
  assign ring_pos_next  = (slot_inc >= p) ? '0 : AW'(slot_inc);
  assign bars_seen_next = (bars_seen <= p) ? bars_seen + 1'b1 : bars_seen;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign ram_we   = (state == S_SUB);

  mfi_ram #(
    .WIDTH (FW + 1),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({neg, flow}),
    .raddr (slot_c),
    .rdata (ram_rdata)
  );

  // pos * 6553600 = (pos*16 + pos*9) << 18
  assign div_num = ((NUM_W'(pos_sum) << 4) + NUM_W'(pos9)) << SCALE_SHIFT;

  always_comb begin
    div_ctl.start = (state == S_SCALE) && (total != '0);
    div_ctl.full  = pos_sum > total;   // sums wrapped: quotient may be wide
  end

  mfi_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (div_num),
    .den (total),
    .sts (div_sts),
    .quo (div_quo)
  );

  // control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WINDOW_RESET;
      pos_sum       <= '0;
      neg_sum       <= '0;
      prev_typ      <= '0;
      ring_pos      <= '0;
      bars_seen     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if ((state == S_EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.series_start) begin
              pos_sum   <= '0;
              neg_sum   <= '0;
              ring_pos  <= '0;
              bars_seen <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prev_typ <= typ;
          if (bars_seen == '0) begin
            bars_seen <= PW'(1);
            state     <= S_IDLE;
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          // retire the oldest flow once the window is full
          if (bars_seen > p) begin
            if (ram_rdata[FW]) begin
              neg_sum <= neg_sum - SUM_W'(ram_rdata[FW-1:0]);
            end else begin
              pos_sum <= pos_sum - SUM_W'(ram_rdata[FW-1:0]);
            end
          end
          state <= S_ADD;
        end
        S_ADD: begin
          if (neg) begin
            neg_sum <= neg_sum + SUM_W'(flow);
          end else begin
            pos_sum <= pos_sum + SUM_W'(flow);
          end
          ring_pos  <= ring_pos_next;
          bars_seen <= bars_seen_next;
          state     <= (bars_seen_next > p) ? S_TOT : S_IDLE;
        end
        S_TOT: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= (total == '0) ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          if (div_sts.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        window_length <= cfg_wdata;
        pos_sum       <= '0;
        neg_sum       <= '0;
        ring_pos      <= '0;
        bars_seen     <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          typ <= TYPW'(in_data.bar_high[PB-1:0]) + TYPW'(in_data.bar_low[PB-1:0])
               + TYPW'(in_data.bar_close[PB-1:0]);
          vol <= in_data.bar_volume[VOLUME_BITS-1:0];
        end
      end
      S_MUL: begin
        flow <= (typ == prev_typ) ? '0 : FW'(typ) * FW'(vol);
        neg  <= typ < prev_typ;
        slot <= slot_c;
      end
      S_TOT: begin
        total <= pos_sum + neg_sum;
        pos9  <= {pos_sum, 3'b000} + (SUM_W + 4)'(pos_sum);
      end
      S_SCALE: begin
        res.index_value  <= '0;
        res.window_empty <= (total == '0);
      end
      S_DIV: begin
        if (div_sts.done) begin
          res.index_value <= div_quo;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_ring_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (PW'(ring_pos) < p))
    else $error("ring position outside the window");

  a_bars_sat: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (bars_seen <= p + 1'b1))
    else $error("bar count past saturation");
`endif

endmodule

>>> dv/tb_money_flow_index.sv
// ----------------------------------------------------------------------------
// tb_money_flow_index: self-checking bench for the money flow index block
// Bars are queued by a stimulus process and sent by a clocked driver that
// works out the expected index beat, if any, for every accepted bar. A clocked monitor
// checks each output beat against the oldest expected one. The run goes
// through several window lengths, clamped values among them.
// ----------------------------------------------------------------------------
module tb_money_flow_index
  import mfi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = 64;
  localparam int SETTLE      = 40;    // settle time at the end of a drain
  localparam int STUCK_LIMIT = 3000;
  localparam int IDLE_PCT    = 37;
  localparam logic [PRICE_W-1:0]  PRICE_MAX  = '1;
  localparam logic [VOLUME_W-1:0] VOLUME_MAX = '1;
  localparam logic [127:0]        FULL_SCALE = 128'd6553600;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  money_flow_index dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  in_beat_t  bar_queue[$];
  out_beat_t index_expected[$];
  bit        no_gaps = 1'b0;
  int        mismatches = 0;
  int        stuck_cycles = 0;

  // predictor state
  logic [CFG_W-1:0] win_reg = WINDOW_RESET;
  logic [63:0]      flow_hist [RING_DEPTH];
  bit               flow_down [RING_DEPTH];
  logic [SUM_W-1:0] rise_sum = '0;
  logic [SUM_W-1:0] fall_sum = '0;
  logic [25:0]      last_typical = '0;
  int               ring_at = 0;
  int               bars_in = 0;

  function automatic void restart_series();
    rise_sum = '0;
    fall_sum = '0;
    ring_at  = 0;
    bars_in  = 0;
  endfunction

  function automatic void predict_index(in_beat_t b);
    int               p;
    logic [25:0]      typical;
    logic [63:0]      flow;
    bit               down;
    logic [SUM_W-1:0] total;
    logic [127:0]     quot;
    out_beat_t        r;
    p = (win_reg == 0) ? 1 : (win_reg > RING_DEPTH) ? RING_DEPTH : int'(win_reg);
    if (b.series_start) restart_series();
    typical = 26'(b.bar_high) + 26'(b.bar_low) + 26'(b.bar_close);
    if (bars_in == 0) begin
      last_typical = typical;
      bars_in = 1;
      return;
    end
    if (typical == last_typical) begin
      flow = '0;
      down = 1'b0;
    end else begin
      flow = 64'(typical) * 64'(b.bar_volume);
      down = typical < last_typical;
    end
    last_typical = typical;
    if (ring_at >= p) ring_at = 0;
    // oldest flow drops out once the window is full
    if (bars_in > p) begin
      if (flow_down[ring_at]) fall_sum -= flow_hist[ring_at];
      else rise_sum -= flow_hist[ring_at];
    end
    flow_hist[ring_at] = flow;
    flow_down[ring_at] = down;
    if (down) fall_sum += flow;
    else rise_sum += flow;
    ring_at = (ring_at + 1 >= p) ? 0 : ring_at + 1;
    if (bars_in <= p) bars_in++;
    if (bars_in <= p) return;
    total = rise_sum + fall_sum;
    if (total == 0) begin
      r.index_value  = '0;
      r.window_empty = 1'b1;
    end else begin
      quot = (128'(rise_sum) * FULL_SCALE) / 128'(total);
      r.index_value  = quot[INDEX_W-1:0];
      r.window_empty = 1'b0;
    end
    index_expected.push_back(r);
  endfunction

  // driver: one beat in flight, next bar taken from the queue
  always @(posedge clk) begin : drive
    in_beat_t nxt_beat;
    logic     nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_beat  = in_data;
      if (in_valid && in_ready) begin
        predict_index(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && bar_queue.size() > 0 &&
          (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        nxt_beat  = bar_queue.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_beat;
    end
  end

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (index_expected.size() == 0) begin
          $display("%0t: unexpected index beat %0d empty %0b", $realtime,
                   out_data.index_value, out_data.window_empty);
          mismatches++;
        end else begin
          want = index_expected.pop_front();
          if (out_data.index_value !== want.index_value) begin
            $display("%0t: index_value expected %0d actual %0d", $realtime,
                     want.index_value, out_data.index_value);
            mismatches++;
          end
          if (out_data.window_empty !== want.window_empty) begin
            $display("%0t: window_empty expected %0b actual %0b", $realtime,
                     want.window_empty, out_data.window_empty);
            mismatches++;
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_beat_t mk_bar(bit s, logic [PRICE_W-1:0] h, logic [PRICE_W-1:0] l,
                                      logic [PRICE_W-1:0] c, logic [VOLUME_W-1:0] v);
    return '{s, h, l, c, v};
  endfunction

  task automatic write_window(input logic [CFG_W-1:0] len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_reg = len;
    restart_series();
    @(negedge clk);
  endtask

  // all bars sent, all index beats back, then let a fill-only bar finish
  task automatic drain();
    do @(negedge clk);
    while (bar_queue.size() != 0 || in_valid || index_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // series planned at p+1 bars or more with random content; a few stray restarts
  task automatic queue_random(input int p, input int n_bars);
    in_beat_t b;
    in_beat_t prev;
    int       left;
    int       pick;
    int       flat_pct;
    bit       quiet;
    left  = 0;
    quiet = 1'b0;
    prev  = '0;
    for (int k = 0; k < n_bars; k++) begin
      if (left == 0) begin
        left  = p + 1 + $urandom_range(2 * p + 16);
        quiet = ($urandom_range(99) < 20);
        b.series_start = (k == 0) ? 1'($urandom_range(1)) : 1'b1;
      end else begin
        b.series_start = ($urandom_range(99) < 1);
      end
      flat_pct = quiet ? 70 : 15;
      pick = $urandom_range(99);
      if (pick < flat_pct) begin
        // same typical price, fields rotated
        b.bar_high  = prev.bar_low;
        b.bar_low   = prev.bar_close;
        b.bar_close = prev.bar_high;
      end else if (pick < flat_pct + 8) begin
        b.bar_high  = $urandom_range(1) ? PRICE_MAX : '0;
        b.bar_low   = $urandom_range(1) ? PRICE_MAX : '0;
        b.bar_close = $urandom_range(1) ? PRICE_MAX : '0;
      end else if (pick < flat_pct + 30) begin
        b.bar_high  = prev.bar_high + PRICE_W'($urandom_range(64)) - PRICE_W'(32);
        b.bar_low   = prev.bar_low + PRICE_W'($urandom_range(64)) - PRICE_W'(32);
        b.bar_close = prev.bar_close + PRICE_W'($urandom_range(64)) - PRICE_W'(32);
      end else begin
        b.bar_high  = PRICE_W'($urandom);
        b.bar_low   = PRICE_W'($urandom);
        b.bar_close = PRICE_W'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < (quiet ? 50 : 10)) b.bar_volume = '0;
      else if (pick < (quiet ? 55 : 15)) b.bar_volume = VOLUME_MAX;
      else if (pick < 40) b.bar_volume = VOLUME_W'($urandom_range(1000));
      else b.bar_volume = $urandom;
      bar_queue.push_back(b);
      prev = b;
      left--;
    end
  endtask

  initial begin : stimulus
    int windows[8];
    windows = '{1, 64, 2, 127, 7, 65, 3, 33};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset window of 14: extremes of every field, rises, falls, unchanged
    bar_queue.push_back(mk_bar(1'b1, '0, '0, '0, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, '0, '0, '0, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, '0, '0, 32'd1));
    bar_queue.push_back(mk_bar(1'b0, '0, PRICE_MAX, '0, 32'd7));
    bar_queue.push_back(mk_bar(1'b0, '0, '0, PRICE_MAX, '0));
    bar_queue.push_back(mk_bar(1'b0, 24'h555555, 24'hAAAAAA, 24'h000001, 32'h5555AAAA));
    bar_queue.push_back(mk_bar(1'b0, 24'hAAAAAA, 24'h000001, 24'h555555, 32'hAAAA5555));
    bar_queue.push_back(mk_bar(1'b0, 24'h123456, 24'h654321, 24'h0F0F0F, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, PRICE_MAX, 24'hFFFFFE, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, '0, '0, '0, 32'd100));
    bar_queue.push_back(mk_bar(1'b0, 24'd5, 24'd3, 24'd1, 32'd100));
    bar_queue.push_back(mk_bar(1'b0, 24'd1, 24'd5, 24'd3, 32'd100));
    bar_queue.push_back(mk_bar(1'b0, 24'd2, 24'd2, 24'd2, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, 24'd9, 24'd9, 24'd9, VOLUME_MAX));
    drain();

    // zero length acts as one: empty window, full rise, full fall, restart
    write_window('0);
    bar_queue.push_back(mk_bar(1'b1, 24'd10, 24'd20, 24'd30, 32'd50));
    bar_queue.push_back(mk_bar(1'b0, 24'd30, 24'd10, 24'd20, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, '0, '0, '0, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b1, 24'd100, 24'd100, 24'd100, 32'd3));
    bar_queue.push_back(mk_bar(1'b0, 24'd200, 24'd100, 24'd100, '0));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX));
    bar_queue.push_back(mk_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, 32'd1));
    bar_queue.push_back(mk_bar(1'b0, '0, PRICE_MAX, '0, VOLUME_MAX));
    drain();

    foreach (windows[i]) begin
      write_window(CFG_W'(windows[i]));
      no_gaps = (i == 4);
      queue_random((windows[i] == 0) ? 1 : (windows[i] > RING_DEPTH) ? RING_DEPTH
                   : windows[i], 212);
      drain();
    end
    no_gaps = 1'b0;

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
